/* rtl/core/trap_pkg.sv */
// Shared constants, types and handshake structs for the tiered rate averager.
package trap_pkg;

	// Default sizing of the wheel and of the used event-count bits.
	localparam int WHEEL_DEF      = 60;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field and state widths.
	localparam int CNT_W   = 16;
	localparam int TS_W    = 6;
	localparam int IDX_W   = 6;
	localparam int SUM_W   = 22;
	localparam int WRAP_W  = 32;

	// Serial divider sizing: numerator carries a sum plus half the divisor.
	localparam int DIV_NUM_W = SUM_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// Request from the sequencer to the shared divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [TS_W-1:0]      den;
	} div_req_t;

	// Response from the divider: one-cycle done with a saturated quotient.
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] quot;
	} div_rsp_t;

endpackage

/* rtl/core/trap_in_if.sv */
// Input channel carrying one event count word per tick.
interface trap_in_if import trap_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] event_count;

	modport source (output valid, output event_count, input ready);
	modport sink (input valid, input event_count, output ready);

endinterface

/* rtl/core/trap_out_if.sv */
// Output channel carrying one result word per closed minute.
interface trap_out_if import trap_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  minute_average;
	logic [CNT_W-1:0]  minute_peak;
	logic              hour_closed;
	logic [CNT_W-1:0]  hour_average;
	logic [CNT_W-1:0]  hour_peak;
	logic [WRAP_W-1:0] hour_wraps;

	modport source (output valid, output minute_average, output minute_peak,
		output hour_closed, output hour_average, output hour_peak,
		output hour_wraps, input ready);
	modport sink (input valid, input minute_average, input minute_peak,
		input hour_closed, input hour_average, input hour_peak,
		input hour_wraps, output ready);

endinterface

/* rtl/core/trap_divider.sv */
// Shared restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
module trap_divider import trap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]      den_q;
	logic [TS_W-1:0]      rem_q;
	logic [DIV_NUM_W-1:0] nq_q;

	logic [TS_W:0]        rem_sh;
	logic                 ge;
	logic [TS_W:0]        rem_diff;

	// One trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		rem_sh   = {rem_q, nq_q[DIV_NUM_W-1]};
		ge       = (rem_sh >= {1'b0, den_q});
		rem_diff = rem_sh - {1'b0, den_q};
	end

	// Control of the iteration count and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Numerator shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? rem_diff[TS_W-1:0] : rem_sh[TS_W-1:0];
		end
	end

	// Quotients beyond the field width saturate.
	assign rsp.done = done_q;
	assign rsp.quot = (nq_q[DIV_NUM_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : nq_q[CNT_W-1:0];

endmodule

/* rtl/core/trap_ctrl.sv */
// Sequencer holding the tick, minute and hour accumulators and the result register.
module trap_ctrl import trap_pkg::*; #(
	parameter int WHEEL      = WHEEL_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic [TS_W-1:0]  tick_seconds,
	input  logic [IDX_W-1:0] minute_ticks,
	trap_in_if.sink       tick,
	trap_out_if.source    report,
	output div_req_t      div_req,
	input  div_rsp_t      div_rsp
);

	localparam logic [CNT_W-1:0] CNT_MASK = (COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} :
		CNT_W'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [DIV_NUM_W-1:0] HALF_WHEEL = DIV_NUM_W'(WHEEL / 2);
	localparam logic [TS_W-1:0]      WHEEL_DEN  = TS_W'(WHEEL);
	localparam logic [IDX_W-1:0]     WHEEL_IDX  = IDX_W'(WHEEL);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_AVG_GO    = 4'd1;
	localparam logic [3:0] ST_AVG_WAIT  = 4'd2;
	localparam logic [3:0] ST_PEAK_GO   = 4'd3;
	localparam logic [3:0] ST_PEAK_WAIT = 4'd4;
	localparam logic [3:0] ST_MIN_CLOSE = 4'd5;
	localparam logic [3:0] ST_HOUR_GO   = 4'd6;
	localparam logic [3:0] ST_HOUR_WAIT = 4'd7;
	localparam logic [3:0] ST_EMIT      = 4'd8;

	logic [3:0]        state_q;
	logic [SUM_W-1:0]  tick_sum_q;
	logic [CNT_W-1:0]  tick_max_q;
	logic [IDX_W-1:0]  tick_idx_q;
	logic [SUM_W-1:0]  min_sum_q;
	logic [CNT_W-1:0]  min_pmax_q;
	logic [IDX_W-1:0]  min_idx_q;
	logic [IDX_W-1:0]  hour_idx_q;
	logic [WRAP_W-1:0] wrap_q;
	logic [CNT_W-1:0]  m_avg_q;
	logic [CNT_W-1:0]  m_peak_q;
	logic              h_closed_q;
	logic [CNT_W-1:0]  h_avg_q;
	logic [CNT_W-1:0]  h_peak_q;

	logic              out_valid_q;
	logic [CNT_W-1:0]  out_m_avg_q;
	logic [CNT_W-1:0]  out_m_peak_q;
	logic              out_h_closed_q;
	logic [CNT_W-1:0]  out_h_avg_q;
	logic [CNT_W-1:0]  out_h_peak_q;
	logic [WRAP_W-1:0] out_wraps_q;

	logic [CNT_W-1:0]  n;
	logic [SUM_W-1:0]  sum_nxt;
	logic [CNT_W-1:0]  max_nxt;
	logic [IDX_W-1:0]  tick_idx_nxt;
	logic [SUM_W-1:0]  min_sum_nxt;
	logic [CNT_W-1:0]  min_pmax_nxt;
	logic [IDX_W-1:0]  min_idx_nxt;
	logic [IDX_W-1:0]  hour_idx_nxt;
	logic              accept;
	logic              emit_load;

	// Tick accumulation and minute roll-up arithmetic.
	always_comb begin
		n            = tick.event_count & CNT_MASK;
		sum_nxt      = tick_sum_q + SUM_W'(n);
		max_nxt      = (n > tick_max_q) ? n : tick_max_q;
		tick_idx_nxt = tick_idx_q + 1'b1;
		min_sum_nxt  = min_sum_q + SUM_W'(m_avg_q);
		min_pmax_nxt = (m_peak_q > min_pmax_q) ? m_peak_q : min_pmax_q;
		min_idx_nxt  = min_idx_q + 1'b1;
		hour_idx_nxt = hour_idx_q + 1'b1;
	end

	assign tick.ready = (state_q == ST_IDLE);
	assign accept     = tick.valid && tick.ready;
	assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || report.ready);

	// Divider operands depend on which rounded division is due.
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = WHEEL_DEN;
		priority if (state_q == ST_AVG_GO) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NUM_W'(tick_sum_q) + HALF_WHEEL;
		end else if (state_q == ST_PEAK_GO) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NUM_W'(tick_max_q) + DIV_NUM_W'(tick_seconds >> 1);
			div_req.den   = tick_seconds;
		end else if (state_q == ST_HOUR_GO) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NUM_W'(min_sum_q) + HALF_WHEEL;
		end else begin
			div_req.start = 1'b0;
		end
	end

	// Sequencer and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_sum_q <= '0;
			tick_max_q <= '0;
			tick_idx_q <= '0;
			min_sum_q  <= '0;
			min_pmax_q <= '0;
			min_idx_q  <= '0;
			hour_idx_q <= '0;
			wrap_q     <= '0;
		end else if (clear) begin
			state_q    <= ST_IDLE;
			tick_sum_q <= '0;
			tick_max_q <= '0;
			tick_idx_q <= '0;
			min_sum_q  <= '0;
			min_pmax_q <= '0;
			min_idx_q  <= '0;
			hour_idx_q <= '0;
			wrap_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tick_sum_q <= sum_nxt;
						tick_max_q <= max_nxt;
						tick_idx_q <= tick_idx_nxt;
						if (tick_idx_nxt >= minute_ticks) begin
							state_q <= ST_AVG_GO;
						end
					end
				end
				ST_AVG_GO: begin
					state_q <= ST_AVG_WAIT;
				end
				ST_AVG_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_PEAK_GO;
					end
				end
				ST_PEAK_GO: begin
					state_q <= ST_PEAK_WAIT;
				end
				ST_PEAK_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_MIN_CLOSE;
					end
				end
				ST_MIN_CLOSE: begin
					tick_sum_q <= '0;
					tick_max_q <= '0;
					tick_idx_q <= '0;
					min_sum_q  <= min_sum_nxt;
					if (min_idx_nxt >= WHEEL_IDX) begin
						min_pmax_q <= '0;
						min_idx_q  <= '0;
						if (hour_idx_nxt >= WHEEL_IDX) begin
							hour_idx_q <= '0;
							wrap_q     <= wrap_q + 1'b1;
						end else begin
							hour_idx_q <= hour_idx_nxt;
						end
						state_q <= ST_HOUR_GO;
					end else begin
						min_pmax_q <= min_pmax_nxt;
						min_idx_q  <= min_idx_nxt;
						state_q    <= ST_EMIT;
					end
				end
				ST_HOUR_GO: begin
					state_q <= ST_HOUR_WAIT;
				end
				ST_HOUR_WAIT: begin
					if (div_rsp.done) begin
						min_sum_q <= '0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured division results and hour values for the pending word.
	always_ff @(posedge clk) begin
		if (state_q == ST_AVG_WAIT && div_rsp.done) begin
			m_avg_q <= div_rsp.quot;
		end
		if (state_q == ST_PEAK_WAIT && div_rsp.done) begin
			m_peak_q <= div_rsp.quot;
		end
		if (state_q == ST_MIN_CLOSE) begin
			h_closed_q <= (min_idx_nxt >= WHEEL_IDX);
			h_peak_q   <= min_pmax_nxt;
		end
		if (state_q == ST_HOUR_WAIT && div_rsp.done) begin
			h_avg_q <= div_rsp.quot;
		end
	end

	// Output register decouples the result from the next tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_m_avg_q    <= m_avg_q;
			out_m_peak_q   <= m_peak_q;
			out_h_closed_q <= h_closed_q;
			out_h_avg_q    <= h_closed_q ? h_avg_q : '0;
			out_h_peak_q   <= h_closed_q ? h_peak_q : '0;
			out_wraps_q    <= wrap_q;
		end
	end

	assign report.valid          = out_valid_q;
	assign report.minute_average = out_m_avg_q;
	assign report.minute_peak    = out_m_peak_q;
	assign report.hour_closed    = out_h_closed_q;
	assign report.hour_average   = out_h_avg_q;
	assign report.hour_peak      = out_h_peak_q;
	assign report.hour_wraps     = out_wraps_q;

endmodule

/* rtl/core/tiered_rate_average_peak.sv */
// A tick that does not close a minute is taken and leaves the block idle and ready for the next.
// A minute-closing tick runs two rounded divisions on the shared serial divider, each a
// start, one quotient bit per cycle for the 23 numerator bits, and a done; its word is then
// offered and the block ready again, later if the previous word is still held. An hour-closing
// tick adds a third division. Reset sets tick_seconds to 1; reset and an accepted write clear
// sequencer and accumulators, reset also output valid, and a non-divisor write is dropped.
module tiered_rate_average_peak import trap_pkg::*; #(
	parameter int WHEEL      = WHEEL_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [TS_W-1:0] cfg_wdata,
	trap_in_if.sink         tick,
	trap_out_if.source      report
);

	localparam int TS_CODES = 2 ** TS_W;

	logic [TS_CODES-1:0] ts_ok;
	logic [IDX_W-1:0]    tpw_tab [TS_CODES];
	logic [TS_W-1:0]     ts_q;
	logic [IDX_W-1:0]    tpw_q;
	logic                cfg_take;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// Constant tables: which tick lengths divide the wheel, and ticks per minute for each.
	for (genvar g = 0; g < TS_CODES; g++) begin : g_ts
		if (g == 0) begin : g_zero
			assign ts_ok[g]   = 1'b0;
			assign tpw_tab[g] = '0;
		end else begin : g_div
			localparam int WHEEL_REM   = WHEEL % g;
			localparam int WHEEL_TICKS = WHEEL / g;
			assign ts_ok[g]   = (WHEEL_REM == 0);
			assign tpw_tab[g] = IDX_W'(WHEEL_TICKS);
		end
	end

	assign cfg_take = cfg_we && ts_ok[cfg_wdata];

	// Tick length register and its derived ticks per minute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= TS_W'(1);
			tpw_q <= IDX_W'(WHEEL);
		end else if (cfg_take) begin
			ts_q  <= cfg_wdata;
			tpw_q <= tpw_tab[cfg_wdata];
		end
	end

	trap_ctrl #(
		.WHEEL      (WHEEL),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_take),
		.tick_seconds (ts_q),
		.minute_ticks (tpw_q),
		.tick         (tick),
		.report       (report),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	trap_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
